/* rtl/xdec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xdec_pkg
// Types, codes and opcode lookup for the x86 subset decoder.
// ----------------------------------------------------------------------------
package xdec_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_UNK   = 2'd2;

  localparam logic [3:0] K_POP   = 4'd0;
  localparam logic [3:0] K_PUSH  = 4'd1;
  localparam logic [3:0] K_RET   = 4'd2;
  localparam logic [3:0] K_CLI   = 4'd3;
  localparam logic [3:0] K_STI   = 4'd4;
  localparam logic [3:0] K_NOP   = 4'd5;
  localparam logic [3:0] K_OUT   = 4'd6;
  localparam logic [3:0] K_SHIFT = 4'd7;
  localparam logic [3:0] K_MOV   = 4'd8;
  localparam logic [3:0] K_ADD   = 4'd9;
  localparam logic [3:0] K_SUB   = 4'd10;
  localparam logic [3:0] K_CMP   = 4'd11;
  localparam logic [3:0] K_CALL  = 4'd12;
  localparam logic [3:0] K_JUMP  = 4'd13;

  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [7:0] PFX_OPSZ = 8'h66;
  localparam logic [7:0] PFX_ADSZ = 8'h67;
  localparam logic [3:0] MAX_LEN  = 4'd15;

  // immediate size codes, resolved against prefixes later
  localparam logic [2:0] IM_NONE = 3'd0;
  localparam logic [2:0] IM_1    = 3'd1;
  localparam logic [2:0] IM_2    = 3'd2;
  localparam logic [2:0] IM_V    = 3'd3;
  localparam logic [2:0] IM_VW   = 3'd4;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       buffer_end;
  } xdec_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  instr_class;
    logic [3:0]  instr_length;
    logic [8:0]  opcode_value;
    logic [6:0]  prefix_flags;
    logic [7:0]  modrm_value;
    logic [2:0]  addressing_flags;
    logic [7:0]  sib_value;
    logic [31:0] displacement;
    logic [63:0] immediate;
    logic [3:0]  immediate_bytes;
  } xdec_out_t;

  typedef struct packed {
    logic       known;
    logic [3:0] cls;
    logic       modrm;
    logic [2:0] imm;
  } xdec_op_info_t;

endpackage
`default_nettype wire

/* rtl/xdec_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xdec_lookup
// Opcode table: class, ModRM presence and immediate size code.
// ----------------------------------------------------------------------------
module xdec_lookup
  import xdec_pkg::*;
(
  input  wire logic [8:0]    op,
  output xdec_op_info_t      info
);

  logic [7:0] lo;
  assign lo = op[7:0];

  always_comb begin
    info = '{known: 1'b1, cls: K_POP, modrm: 1'b0, imm: IM_NONE};
    if (op[8]) begin
      if (lo == 8'hA0 || lo == 8'hA8) info.cls = K_PUSH;
      else if (lo == 8'hA1 || lo == 8'hA9) info.cls = K_POP;
      else if (lo == 8'h1F) begin info.cls = K_NOP; info.modrm = 1'b1; end
      else if (lo == 8'h20 || lo == 8'h22) begin info.cls = K_MOV; info.modrm = 1'b1; end
      else if (lo[7:4] == 4'h8) begin info.cls = K_JUMP; info.imm = IM_V; end
      else info.known = 1'b0;
    end else if (lo <= 8'h03) begin info.cls = K_ADD; info.modrm = 1'b1; end
    else if (lo >= 8'h28 && lo <= 8'h2B) begin info.cls = K_SUB; info.modrm = 1'b1; end
    else if (lo >= 8'h38 && lo <= 8'h3B) begin info.cls = K_CMP; info.modrm = 1'b1; end
    else if (lo >= 8'h50 && lo <= 8'h57) info.cls = K_PUSH;
    else if (lo >= 8'h58 && lo <= 8'h5F) info.cls = K_POP;
    else if (lo[7:4] == 4'h7) begin info.cls = K_JUMP; info.imm = IM_1; end
    else if (lo >= 8'h88 && lo <= 8'h8D) begin info.cls = K_MOV; info.modrm = 1'b1; end
    else if (lo >= 8'hB0 && lo <= 8'hB7) begin info.cls = K_MOV; info.imm = IM_1; end
    else if (lo >= 8'hB8 && lo <= 8'hBF) begin info.cls = K_MOV; info.imm = IM_VW; end
    else if (lo >= 8'hD0 && lo <= 8'hD3) begin info.cls = K_SHIFT; info.modrm = 1'b1; end
    else begin
      case (lo)
        8'h04: begin info.cls = K_ADD; info.imm = IM_1; end
        8'h05: begin info.cls = K_ADD; info.imm = IM_V; end
        8'h2C: begin info.cls = K_SUB; info.imm = IM_1; end
        8'h2D: begin info.cls = K_SUB; info.imm = IM_V; end
        8'h3C: begin info.cls = K_CMP; info.imm = IM_1; end
        8'h3D: begin info.cls = K_CMP; info.imm = IM_V; end
        8'h06, 8'h0E, 8'h16, 8'h1E, 8'h60, 8'h9C: info.cls = K_PUSH;
        8'h07, 8'h17, 8'h1F, 8'h61, 8'h9D: info.cls = K_POP;
        8'h68: begin info.cls = K_PUSH; info.imm = IM_V; end
        8'h6A: begin info.cls = K_PUSH; info.imm = IM_1; end
        8'h80, 8'h83: begin info.modrm = 1'b1; info.imm = IM_1; end
        8'h81: begin info.modrm = 1'b1; info.imm = IM_V; end
        8'h8F: begin info.cls = K_POP; info.modrm = 1'b1; end
        8'h90: info.cls = K_NOP;
        8'h9A: begin info.cls = K_CALL; info.imm = IM_VW; end
        8'hA0, 8'hA1, 8'hA3: begin info.cls = K_MOV; info.imm = IM_VW; end
        8'hC0, 8'hC1: begin info.cls = K_SHIFT; info.modrm = 1'b1; info.imm = IM_1; end
        8'hC2, 8'hCA: begin info.cls = K_RET; info.imm = IM_2; end
        8'hC3, 8'hCB: info.cls = K_RET;
        8'hC6: begin info.cls = K_MOV; info.modrm = 1'b1; info.imm = IM_1; end
        8'hC7: begin info.cls = K_MOV; info.modrm = 1'b1; info.imm = IM_V; end
        8'hE3, 8'hEB: begin info.cls = K_JUMP; info.imm = IM_1; end
        8'hE6, 8'hE7: begin info.cls = K_OUT; info.imm = IM_1; end
        8'hEE, 8'hEF: info.cls = K_OUT;
        8'hE8: begin info.cls = K_CALL; info.imm = IM_V; end
        8'hE9, 8'hEA: begin info.cls = K_JUMP; info.imm = IM_V; end
        8'hFA: info.cls = K_CLI;
        8'hFB: info.cls = K_STI;
        8'hFF: info.modrm = 1'b1;
        default: info.known = 1'b0;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/x86_instruction_subset_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// x86_instruction_subset_decoder_core
// Byte-serial decoder for a subset of x86 instructions.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle while the input is not stalled. Each byte
// updates a small phase machine and the field registers when it is taken;
// when an instruction completes, hits buffer end, or fails, one result item
// is written to the output register. The next byte is taken in the same cycle
// a result is still waiting, as long as the output register is free or being
// drained; the result is registered, appearing in the cycle after its last byte.
module x86_instruction_subset_decoder_core
  import xdec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  xdec_in_t       in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output xdec_out_t      out_data
);

  typedef enum logic [2:0] {
    PH_OPC, PH_ESC, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
  } phase_t;

  phase_t      phase, phase_next;
  logic        addressing_64;
  logic [3:0]  byte_count;
  logic [8:0]  opcode_reg, opcode_next;
  logic [6:0]  prefix_reg, prefix_next;
  logic [7:0]  modrm_reg, modrm_next;
  logic [7:0]  sib_reg, sib_next;
  logic [2:0]  aflags_reg, aflags_next;
  logic [31:0] disp_reg, disp_next;
  logic [63:0] imm_reg, imm_next;
  logic [3:0]  remain, remain_next;
  logic [3:0]  imm_size, imm_size_next;
  logic [3:0]  disp_pos, disp_pos_next;
  logic [3:0]  class_reg, class_next;

  logic [7:0]  b;
  logic [3:0]  cnt;
  logic        take, emit, fin_ok, fail_unk;
  logic [1:0]  st;
  xdec_op_info_t info;
  xdec_out_t   res;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign take      = in_valid & ~in_stall;
  assign b         = in_data.code_byte;
  assign cnt       = byte_count + 4'd1;

  xdec_lookup u_lookup (.op(opcode_next), .info(info));

  function automatic logic [3:0] imm_bytes(input logic [2:0] code, input logic [6:0] pf);
    case (code)
      IM_1:    imm_bytes = 4'd1;
      IM_2:    imm_bytes = 4'd2;
      IM_V:    imm_bytes = pf[0] ? 4'd2 : 4'd4;
      IM_VW:   imm_bytes = pf[6] ? 4'd8 : (pf[0] ? 4'd2 : 4'd4);
      default: imm_bytes = 4'd0;
    endcase
  endfunction

  // displacement size from a ModRM byte (and SIB when known)
  function automatic logic [2:0] disp_sz(input logic [7:0] m, input logic wide,
                                         input logic has_sib, input logic [7:0] s);
    if (m[7:6] == 2'd3) disp_sz = 3'd0;
    else if (m[7:6] == 2'd1) disp_sz = 3'd1;
    else if (wide) begin
      if (m[7:6] == 2'd2 || m[2:0] == 3'd5 || (has_sib && s[2:0] == 3'd5)) disp_sz = 3'd4;
      else disp_sz = 3'd0;
    end else if (m[7:6] == 2'd2 || m[2:0] == 3'd6) disp_sz = 3'd2;
    else disp_sz = 3'd0;
  endfunction

  logic       wide;
  logic [2:0] dsz;
  logic       sib_need;

  always_comb begin
    phase_next    = phase;
    opcode_next   = opcode_reg;
    prefix_next   = prefix_reg;
    modrm_next    = modrm_reg;
    sib_next      = sib_reg;
    aflags_next   = aflags_reg;
    disp_next     = disp_reg;
    imm_next      = imm_reg;
    remain_next   = remain;
    imm_size_next = imm_size;
    disp_pos_next = disp_pos;
    class_next    = class_reg;
    fin_ok        = 1'b0;
    fail_unk      = 1'b0;
    wide          = addressing_64 | prefix_reg[1];
    dsz           = 3'd0;
    sib_need      = 1'b0;

    case (phase)
      PH_OPC: begin
        if (b == PFX_OPSZ) prefix_next[0] = 1'b1;
        else if (b == PFX_ADSZ) prefix_next[1] = 1'b1;
        else if (b[7:4] == 4'h4) prefix_next = {b[3:0], 1'b1, prefix_reg[1:0]};
        else if (b == OP_ESC) phase_next = PH_ESC;
        else opcode_next = {1'b0, b};
      end
      PH_ESC: opcode_next = {1'b1, b};
      PH_MODRM: begin
        modrm_next = b;
        aflags_next[0] = 1'b1;
        if (opcode_reg == 9'h080 || opcode_reg == 9'h081 || opcode_reg == 9'h083) begin
          case (b[5:3])
            3'd0: class_next = K_ADD;
            3'd5: class_next = K_SUB;
            3'd7: class_next = K_CMP;
            default: fail_unk = 1'b1;
          endcase
        end else if (opcode_reg == 9'h0FF) begin
          case (b[5:3])
            3'd2, 3'd3: class_next = K_CALL;
            3'd4, 3'd5: class_next = K_JUMP;
            3'd6: class_next = K_PUSH;
            default: fail_unk = 1'b1;
          endcase
        end
        if (!fail_unk) begin
          sib_need = wide && b[7:6] != 2'd3 && b[2:0] == 3'd4;
          dsz = disp_sz(b, wide, aflags_reg[1], sib_reg);
          if (sib_need || dsz != 3'd0) aflags_next[2] = 1'b1;
          if (sib_need) phase_next = PH_SIB;
          else if (dsz != 3'd0) begin
            phase_next = PH_DISP; remain_next = {1'b0, dsz}; disp_pos_next = 4'd0;
          end else if (imm_size != 4'd0) begin
            phase_next = PH_IMM; remain_next = imm_size;
          end else fin_ok = 1'b1;
        end
      end
      PH_SIB: begin
        sib_next = b;
        aflags_next = aflags_reg | 3'd6;
        dsz = disp_sz(modrm_reg, wide, 1'b1, b);
        if (dsz != 3'd0) begin
          phase_next = PH_DISP; remain_next = {1'b0, dsz}; disp_pos_next = 4'd0;
        end else if (imm_size != 4'd0) begin
          phase_next = PH_IMM; remain_next = imm_size;
        end else fin_ok = 1'b1;
      end
      PH_DISP: begin
        disp_next = disp_reg | ({24'd0, b} << {disp_pos[1:0], 3'd0});
        disp_pos_next = disp_pos + 4'd1;
        remain_next = remain - 4'd1;
        if (remain == 4'd1) begin
          if (imm_size != 4'd0) begin
            phase_next = PH_IMM; remain_next = imm_size;
          end else fin_ok = 1'b1;
        end
      end
      PH_IMM: begin
        imm_next = imm_reg | ({56'd0, b} << {imm_size[2:0] - remain[2:0], 3'd0});
        remain_next = remain - 4'd1;
        if (remain == 4'd1) fin_ok = 1'b1;
      end
      default: phase_next = PH_OPC;
    endcase

    // opcode byte just arrived: consult the table
    if ((phase == PH_OPC && b != PFX_OPSZ && b != PFX_ADSZ && b[7:4] != 4'h4 &&
         b != OP_ESC) || phase == PH_ESC) begin
      if (!info.known) fail_unk = 1'b1;
      else begin
        class_next = info.cls;
        imm_size_next = imm_bytes(info.imm, prefix_next);
        if (info.modrm) phase_next = PH_MODRM;
        else if (imm_size_next != 4'd0) begin
          phase_next = PH_IMM; remain_next = imm_size_next;
        end else fin_ok = 1'b1;
      end
    end
  end

  logic [3:0] ib;
  always_comb begin
    emit = fin_ok | fail_unk | in_data.buffer_end | (cnt >= MAX_LEN);
    if (fin_ok) st = ST_OK;
    else if (fail_unk) st = ST_UNK;
    else if (in_data.buffer_end) st = ST_TRUNC;
    else st = ST_UNK;
    if (fin_ok) ib = imm_size_next;
    else if (phase_next == PH_IMM && !fail_unk) ib = imm_size_next - remain_next;
    else ib = 4'd0;
    res.status           = st;
    res.instr_class      = class_next;
    res.instr_length     = cnt;
    res.opcode_value     = opcode_next;
    res.prefix_flags     = prefix_next;
    res.modrm_value      = modrm_next;
    res.addressing_flags = aflags_next;
    res.sib_value        = sib_next;
    res.displacement     = disp_next;
    res.immediate        = imm_next;
    res.immediate_bytes  = ib;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addressing_64 <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      addressing_64 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && emit)) begin
      phase      <= PH_OPC;
      byte_count <= 4'd0;
      opcode_reg <= '0;
      prefix_reg <= '0;
      modrm_reg  <= '0;
      sib_reg    <= '0;
      aflags_reg <= '0;
      disp_reg   <= '0;
      imm_reg    <= '0;
      remain     <= '0;
      imm_size   <= '0;
      disp_pos   <= '0;
      class_reg  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      byte_count <= cnt;
      opcode_reg <= opcode_next;
      prefix_reg <= prefix_next;
      modrm_reg  <= modrm_next;
      sib_reg    <= sib_next;
      aflags_reg <= aflags_next;
      disp_reg   <= disp_next;
      imm_reg    <= imm_next;
      remain     <= remain_next;
      imm_size   <= imm_size_next;
      disp_pos   <= disp_pos_next;
      class_reg  <= class_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_data <= res;
  end

endmodule
`default_nettype wire

/* rtl/xdec_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xdec_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module xdec_checker
  import xdec_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input xdec_out_t      out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.instr_length != 4'd0)
    else $error("zero-length result item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

  a_ok_imm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |->
      out_data.immediate_bytes <= 4'd8)
    else $error("immediate size out of range");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind x86_instruction_subset_decoder_core xdec_checker u_xdec_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

/* tb/sv/xdec_decode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xdec_decode_checker
// Watches the decoder channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
// Every accepted code byte runs through a local decode machine; a finished
// instruction pushes its expected result. Each accepted result is checked
// field by field against the oldest one. The state before the byte now on
// the input is also offered to the stimulus side as a peek: ends_here says
// whether that byte would close an instruction.
module xdec_decode_checker
  import xdec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_valid,
  input  wire logic  cfg_ready,
  input  wire logic  cfg_data,
  input  wire logic  in_valid,
  input  wire logic  in_stall,
  input  xdec_in_t   in_data,
  input  wire logic  out_valid,
  input  wire logic  out_stall,
  input  xdec_out_t  out_data,
  output int         fails,
  output int         pending,
  output logic       ends_here
);

  typedef enum logic [2:0] {PH_OPC, PH_ESC, PH_MODRM, PH_SIB, PH_DISP, PH_IMM} phase_t;

  localparam int RC_CONT  = 0;
  localparam int RC_OK    = 1;
  localparam int RC_TRUNC = 2;
  localparam int RC_UNK   = 3;

  typedef struct packed {
    phase_t      ph;
    logic [3:0]  cnt;
    logic [3:0]  rem;
    logic [3:0]  isz;
    logic [3:0]  cls;
    logic [6:0]  pfx;
    logic [7:0]  mrm;
    logic [7:0]  sib;
    logic [2:0]  afl;
    logic [8:0]  opc;
    logic [31:0] disp;
    logic [63:0] imm;
  } dec_st_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] cls;
    logic       mr;
    logic [3:0] im;
  } op_desc_t;

  dec_st_t    st;
  logic       wide_mode;
  xdec_out_t  expected_results[$];

  dec_st_t    pk_st;
  xdec_out_t  pk_res;

  function automatic logic [3:0] size_v(dec_st_t s);
    return s.pfx[0] ? 4'd2 : 4'd4;
  endfunction

  function automatic logic [3:0] size_vw(dec_st_t s);
    return s.pfx[6] ? 4'd8 : size_v(s);
  endfunction

  function automatic logic wide(dec_st_t s, logic a);
    return a | s.pfx[1];
  endfunction

  function automatic logic need_sib(dec_st_t s, logic a);
    return wide(s, a) && s.mrm[7:6] != 2'd3 && s.mrm[2:0] == 3'd4;
  endfunction

  function automatic logic [3:0] disp_bytes(dec_st_t s, logic a);
    if (s.mrm[7:6] == 2'd3) return 4'd0;
    if (s.mrm[7:6] == 2'd1) return 4'd1;
    if (wide(s, a)) begin
      if (s.mrm[7:6] == 2'd2) return 4'd4;
      if (s.mrm[2:0] == 3'd5) return 4'd4;
      if (s.afl[1] && s.sib[2:0] == 3'd5) return 4'd4;
      return 4'd0;
    end
    if (s.mrm[7:6] == 2'd2) return 4'd2;
    return (s.mrm[2:0] == 3'd6) ? 4'd2 : 4'd0;
  endfunction

  // stage 0: after ModRM, 1: after SIB, 2: after displacement
  function automatic int advance(inout dec_st_t s, input int stage, input logic a);
    logic [3:0] d;
    if (stage < 1 && need_sib(s, a)) begin
      s.ph = PH_SIB;
      return RC_CONT;
    end
    if (stage < 2) begin
      d = disp_bytes(s, a);
      if (d != 0) begin
        s.ph = PH_DISP;
        s.rem = d;
        return RC_CONT;
      end
    end
    if (s.isz != 0) begin
      s.ph = PH_IMM;
      s.rem = s.isz;
      return RC_CONT;
    end
    return RC_OK;
  endfunction

  function automatic op_desc_t classify(dec_st_t s);
    op_desc_t o;
    logic [7:0] lo;
    lo = s.opc[7:0];
    o = '0;
    o.ok = 1'b1;
    if (s.opc[8]) begin
      if (lo == 8'hA0 || lo == 8'hA8) o.cls = K_PUSH;
      else if (lo == 8'hA1 || lo == 8'hA9) o.cls = K_POP;
      else if (lo == 8'h1F) begin o.cls = K_NOP; o.mr = 1'b1; end
      else if (lo == 8'h20 || lo == 8'h22) begin o.cls = K_MOV; o.mr = 1'b1; end
      else if (lo >= 8'h80 && lo <= 8'h8F) begin o.cls = K_JUMP; o.im = size_v(s); end
      else o.ok = 1'b0;
      return o;
    end
    if (lo <= 8'h03) begin o.cls = K_ADD; o.mr = 1'b1; end
    else if (lo >= 8'h28 && lo <= 8'h2B) begin o.cls = K_SUB; o.mr = 1'b1; end
    else if (lo >= 8'h38 && lo <= 8'h3B) begin o.cls = K_CMP; o.mr = 1'b1; end
    else if (lo >= 8'h50 && lo <= 8'h57) o.cls = K_PUSH;
    else if (lo >= 8'h58 && lo <= 8'h5F) o.cls = K_POP;
    else if (lo >= 8'h70 && lo <= 8'h7F) begin o.cls = K_JUMP; o.im = 4'd1; end
    else if (lo >= 8'h88 && lo <= 8'h8D) begin o.cls = K_MOV; o.mr = 1'b1; end
    else if (lo >= 8'hB0 && lo <= 8'hB7) begin o.cls = K_MOV; o.im = 4'd1; end
    else if (lo >= 8'hB8 && lo <= 8'hBF) begin o.cls = K_MOV; o.im = size_vw(s); end
    else if (lo >= 8'hD0 && lo <= 8'hD3) begin o.cls = K_SHIFT; o.mr = 1'b1; end
    else begin
      case (lo)
        8'h04: begin o.cls = K_ADD; o.im = 4'd1; end
        8'h05: begin o.cls = K_ADD; o.im = size_v(s); end
        8'h2C: begin o.cls = K_SUB; o.im = 4'd1; end
        8'h2D: begin o.cls = K_SUB; o.im = size_v(s); end
        8'h3C: begin o.cls = K_CMP; o.im = 4'd1; end
        8'h3D: begin o.cls = K_CMP; o.im = size_v(s); end
        8'h06, 8'h0E, 8'h16, 8'h1E, 8'h60, 8'h9C: o.cls = K_PUSH;
        8'h07, 8'h17, 8'h1F, 8'h61, 8'h9D: o.cls = K_POP;
        8'h68: begin o.cls = K_PUSH; o.im = size_v(s); end
        8'h6A: begin o.cls = K_PUSH; o.im = 4'd1; end
        8'h80, 8'h83: begin o.mr = 1'b1; o.im = 4'd1; end
        8'h81: begin o.mr = 1'b1; o.im = size_v(s); end
        8'h8F: begin o.cls = K_POP; o.mr = 1'b1; end
        8'h90: o.cls = K_NOP;
        8'h9A: begin o.cls = K_CALL; o.im = size_vw(s); end
        8'hA0, 8'hA1, 8'hA3: begin o.cls = K_MOV; o.im = size_vw(s); end
        8'hC0, 8'hC1: begin o.cls = K_SHIFT; o.mr = 1'b1; o.im = 4'd1; end
        8'hC2, 8'hCA: begin o.cls = K_RET; o.im = 4'd2; end
        8'hC3, 8'hCB: o.cls = K_RET;
        8'hC6: begin o.cls = K_MOV; o.mr = 1'b1; o.im = 4'd1; end
        8'hC7: begin o.cls = K_MOV; o.mr = 1'b1; o.im = size_v(s); end
        8'hE3, 8'hEB: begin o.cls = K_JUMP; o.im = 4'd1; end
        8'hE6, 8'hE7: begin o.cls = K_OUT; o.im = 4'd1; end
        8'hEE, 8'hEF: o.cls = K_OUT;
        8'hE8: begin o.cls = K_CALL; o.im = size_v(s); end
        8'hE9, 8'hEA: begin o.cls = K_JUMP; o.im = size_v(s); end
        8'hFA: o.cls = K_CLI;
        8'hFB: o.cls = K_STI;
        8'hFF: o.mr = 1'b1;
        default: o.ok = 1'b0;
      endcase
    end
    return o;
  endfunction

  function automatic int start_opcode(inout dec_st_t s, input logic a);
    op_desc_t o;
    o = classify(s);
    if (!o.ok) return RC_UNK;
    s.cls = o.cls;
    s.isz = o.im;
    if (o.mr) begin
      s.ph = PH_MODRM;
      return RC_CONT;
    end
    return advance(s, 2, a);
  endfunction

  function automatic int take_modrm(inout dec_st_t s, input logic [7:0] b, input logic a);
    logic [2:0] reg_f;
    reg_f = b[5:3];
    s.mrm = b;
    s.afl[0] = 1'b1;
    if (s.opc == 9'h080 || s.opc == 9'h081 || s.opc == 9'h083) begin
      if (reg_f == 3'd0) s.cls = K_ADD;
      else if (reg_f == 3'd5) s.cls = K_SUB;
      else if (reg_f == 3'd7) s.cls = K_CMP;
      else return RC_UNK;
    end else if (s.opc == 9'h0FF) begin
      if (reg_f == 3'd2 || reg_f == 3'd3) s.cls = K_CALL;
      else if (reg_f == 3'd4 || reg_f == 3'd5) s.cls = K_JUMP;
      else if (reg_f == 3'd6) s.cls = K_PUSH;
      else return RC_UNK;
    end
    if (need_sib(s, a) || disp_bytes(s, a) != 0) s.afl[2] = 1'b1;
    return advance(s, 0, a);
  endfunction

  // Decode one byte; returns 1 with the result when an instruction closes.
  function automatic logic decode_byte(inout dec_st_t s, input logic [7:0] b,
                                       input logic e, input logic a,
                                       output xdec_out_t r);
    logic [4:0] cnt5;
    logic [3:0] idx;
    logic [3:0] ib;
    int rc;
    cnt5 = {1'b0, s.cnt} + 5'd1;
    rc = RC_CONT;
    r = '0;
    s.cnt = cnt5[3:0];
    case (s.ph)
      PH_ESC: begin
        s.opc = {1'b1, b};
        rc = start_opcode(s, a);
      end
      PH_MODRM: rc = take_modrm(s, b, a);
      PH_SIB: begin
        s.sib = b;
        s.afl = s.afl | 3'd6;
        rc = advance(s, 1, a);
      end
      PH_DISP: begin
        if (s.rem == 0) rc = advance(s, 2, a);
        else begin
          idx = (disp_bytes(s, a) - s.rem) & 4'd3;
          s.disp = s.disp | (32'(b) << (8 * idx));
          s.rem = s.rem - 4'd1;
          if (s.rem == 0) rc = advance(s, 2, a);
        end
      end
      PH_IMM: begin
        if (s.rem == 0) rc = RC_OK;
        else begin
          idx = (s.isz - s.rem) & 4'd7;
          s.imm = s.imm | (64'(b) << (8 * idx));
          s.rem = s.rem - 4'd1;
          if (s.rem == 0) rc = RC_OK;
        end
      end
      default: begin
        if (b == PFX_OPSZ) s.pfx[0] = 1'b1;
        else if (b == PFX_ADSZ) s.pfx[1] = 1'b1;
        else if (b[7:4] == 4'h4) s.pfx = {b[3:0], 1'b1, s.pfx[1:0]};
        else if (b == OP_ESC) s.ph = PH_ESC;
        else begin
          s.opc = {1'b0, b};
          rc = start_opcode(s, a);
        end
      end
    endcase
    if (rc == RC_CONT && (e || cnt5 >= 5'd15)) rc = e ? RC_TRUNC : RC_UNK;
    if (rc == RC_CONT) return 1'b0;
    if (rc == RC_OK) ib = s.isz;
    else if (s.ph == PH_IMM) ib = s.isz - s.rem;
    else ib = 4'd0;
    r.status = (rc == RC_OK) ? ST_OK : (rc == RC_TRUNC) ? ST_TRUNC : ST_UNK;
    r.instr_class = s.cls;
    r.instr_length = cnt5[3:0];
    r.opcode_value = s.opc;
    r.prefix_flags = s.pfx;
    r.modrm_value = s.mrm;
    r.addressing_flags = s.afl;
    r.sib_value = s.sib;
    r.displacement = s.disp;
    r.immediate = s.imm;
    r.immediate_bytes = ib;
    s = '0;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // lookahead for the stimulus side
  always_comb begin
    pk_st = st;
    ends_here = decode_byte(pk_st, in_data.code_byte, in_data.buffer_end, wide_mode,
                            pk_res);
  end

  initial fails = 0;

  always @(posedge clk) begin
    xdec_out_t w;
    xdec_out_t r;
    dec_st_t   ns;
    if (rst) begin
      st <= '0;
      wide_mode <= 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          w = expected_results.pop_front();
          check_field("status", out_data.status, w.status);
          check_field("instr_class", out_data.instr_class, w.instr_class);
          check_field("instr_length", out_data.instr_length, w.instr_length);
          check_field("opcode_value", out_data.opcode_value, w.opcode_value);
          check_field("prefix_flags", out_data.prefix_flags, w.prefix_flags);
          check_field("modrm_value", out_data.modrm_value, w.modrm_value);
          check_field("addressing_flags", out_data.addressing_flags, w.addressing_flags);
          check_field("sib_value", out_data.sib_value, w.sib_value);
          check_field("displacement", out_data.displacement, w.displacement);
          check_field("immediate", out_data.immediate, w.immediate);
          check_field("immediate_bytes", out_data.immediate_bytes, w.immediate_bytes);
        end
      end
      if (in_valid && !in_stall) begin
        ns = st;
        if (decode_byte(ns, in_data.code_byte, in_data.buffer_end, wide_mode, r))
          expected_results.push_back(r);
        st <= ns;
      end
      if (cfg_valid && cfg_ready) wide_mode <= cfg_data;
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the x86 subset decoder.
// ----------------------------------------------------------------------------
// Drives directed instructions, then random well-formed instructions mixed
// with noise bytes, under both addressing modes, with random gaps on both
// channels and one long output hold-off. Checking lives in the checker.
module tb;
  import xdec_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  xdec_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  xdec_out_t out_data;

  int   fails;
  int   pending;
  logic ends_here;
  bit   busy_phase = 1'b0;  // no idling on either side
  bit   hold_req = 1'b0;
  int   sent = 0;

  always #5 clk = ~clk;

  x86_instruction_subset_decoder_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  xdec_decode_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fails(fails), .pending(pending), .ends_here(ends_here)
  );

  task automatic send_byte(input logic [7:0] b, input logic e, output bit ended);
    int gap;
    in_data <= '{code_byte: b, buffer_end: e};
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    ended = ends_here;
    @(posedge clk);
    sent++;
    gap = busy_phase ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic burst(input logic [7:0] q[$], input logic end_last);
    bit ended;
    foreach (q[i]) send_byte(q[i], end_last && i == q.size() - 1, ended);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic op_listed(logic [7:0] b);
    if (b <= 8'h07 || (b >= 8'h28 && b <= 8'h2D) || (b >= 8'h38 && b <= 8'h3D)) return 1;
    if ((b >= 8'h50 && b <= 8'h61) || (b >= 8'h70 && b <= 8'h7F)) return 1;
    if ((b >= 8'h88 && b <= 8'h8D) || (b >= 8'hB0 && b <= 8'hBF)) return 1;
    if (b >= 8'hD0 && b <= 8'hD3) return 1;
    case (b)
      8'h0E, 8'h16, 8'h17, 8'h1E, 8'h1F, 8'h68, 8'h6A, 8'h80, 8'h81, 8'h83, 8'h8F,
      8'h90, 8'h9A, 8'h9C, 8'h9D, 8'hA0, 8'hA1, 8'hA3, 8'hC0, 8'hC1, 8'hC2, 8'hC3,
      8'hC6, 8'hC7, 8'hCA, 8'hCB, 8'hE3, 8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hEB,
      8'hEE, 8'hEF, 8'hFA, 8'hFB, 8'hFF: return 1;
      default: return 0;
    endcase
  endfunction

  // one random instruction: prefixes, opcode, then bytes until it closes
  task automatic send_instr();
    logic [7:0] esc_ops[] = '{8'hA0, 8'hA1, 8'hA8, 8'hA9, 8'h1F, 8'h20, 8'h22,
                               8'h80, 8'h84, 8'h8F};
    logic [7:0] op;
    logic [7:0] mb;
    logic [2:0] regs_alu[] = '{3'd0, 3'd5, 3'd7};
    bit ended;
    int n;
    ended = 0;
    n = $urandom_range(0, 3);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_byte(PFX_OPSZ, $urandom_range(0, 39) == 0, ended);
        1: send_byte(PFX_ADSZ, $urandom_range(0, 39) == 0, ended);
        default: send_byte({4'h4, 4'($urandom)}, $urandom_range(0, 39) == 0, ended);
      endcase
      if (ended) return;
    end
    if ($urandom_range(0, 4) == 0) begin
      send_byte(OP_ESC, 1'b0, ended);
      if (ended) return;
      op = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                       : esc_ops[$urandom_range(0, 9)] | 8'($urandom_range(0, 1) * 3 & (0));
      if (op == 8'h84) op = 8'h80 | 8'($urandom_range(0, 15));
      send_byte(op, $urandom_range(0, 39) == 0, ended);
      op = 8'h00;
    end else begin
      do op = 8'($urandom); while (!op_listed(op) && $urandom_range(0, 19) != 0);
      send_byte(op, $urandom_range(0, 39) == 0, ended);
    end
    if (ended) return;
    mb = 8'($urandom);
    if ((op == 8'h80 || op == 8'h81 || op == 8'h83) && $urandom_range(0, 9) != 0)
      mb[5:3] = regs_alu[$urandom_range(0, 2)];
    if (op == 8'hFF && $urandom_range(0, 9) != 0) mb[5:3] = 3'($urandom_range(2, 6));
    send_byte(mb, $urandom_range(0, 39) == 0, ended);
    for (int i = 0; i < 16 && !ended; i++)
      send_byte(8'($urandom), $urandom_range(0, 39) == 0, ended);
  endtask

  task automatic random_phase(input int count);
    bit ended;
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), $urandom_range(0, 7) == 0, ended);
      else send_instr();
    end
  endtask

  // result side: per-item wait, or one long hold-off on request
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        w = 300;
        hold_req = 1'b0;
      end else begin
        w = busy_phase ? 0 : $urandom_range(0, 9);
      end
      out_stall <= (w > 0);
      if (w > 0) begin
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 16-bit addressing
    burst('{8'h90}, 0);
    burst('{8'hC3}, 0);
    burst('{8'h0F, 8'h1F, 8'h44, 8'h00}, 0);
    burst('{8'h66, 8'hB8, 8'h34, 8'h12}, 0);
    burst('{8'h48, 8'hB8, 8'h00, 8'hFF, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'hFF}, 0);
    burst('{8'h80, 8'hC8}, 0);
    burst('{8'hFF, 8'hF8}, 0);
    burst('{8'hD6}, 0);
    burst('{8'h66}, 1);
    burst('{8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
            8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66}, 0);
    burst('{8'h0F, 8'h05}, 0);
    burst('{8'h0F, 8'h84, 8'h78, 8'h56, 8'h34, 8'h12}, 0);
    burst('{8'h8B, 8'h46, 8'h7F}, 0);
    burst('{8'h8B, 8'h06, 8'h11, 8'h22}, 0);
    burst('{8'h41, 8'h48, 8'hC7, 8'hC0, 8'h01, 8'h02, 8'h03, 8'h04}, 0);
    burst('{8'hB8, 8'h01}, 1);
    drain();

    // 32/64-bit addressing
    set_mode(1'b1);
    burst('{8'h8B, 8'h04, 8'h25, 8'h01, 8'h02, 8'h03, 8'h04}, 0);
    burst('{8'h8B, 8'h44, 8'h24, 8'h10}, 0);
    burst('{8'h81, 8'hBC, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44}, 0);
    burst('{8'hC2, 8'h34, 8'h12}, 1);
    burst('{8'hFF, 8'h15, 8'h00, 8'h00, 8'h00}, 1);
    burst('{8'h8F, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04}, 0);
    drain();

    set_mode(1'b0);
    busy_phase = 1'b1;
    random_phase(250);
    drain();
    busy_phase = 1'b0;

    set_mode(1'b1);
    random_phase(150);
    hold_req = 1'b1;
    random_phase(150);
    drain();

    set_mode(1'b0);
    random_phase(260);
    drain();

    set_mode(1'b1);
    random_phase(260);
    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);

    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/xdec_pkg.sv
rtl/xdec_lookup.sv
rtl/x86_instruction_subset_decoder_core.sv
rtl/xdec_checker.sv
tb/sv/xdec_decode_checker.sv
tb/sv/tb.sv
